// ----- rtl/stbs_pkg.sv -----
// Shared types and codes for the sorted-table binary search block.
// No dependencies; imported by the top level.
package stbs_pkg;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SEARCH = 1'b1
    } t_func;

    localparam int unsigned COUNT_BITS = 9;
    localparam int unsigned POS_BITS   = 9;
    localparam int unsigned INDEX_BITS = 8;
    localparam int unsigned IKEY_BITS  = 32;

    typedef struct packed {
        t_func                        func;
        logic [INDEX_BITS-1:0]        entry_index;
        logic signed [IKEY_BITS-1:0]  key_value;
    } t_cmd;

    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                found;
    } t_res;

endpackage

// ----- rtl/stbs_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module stbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sorted_table_binary_search_top.sv -----
// Sorted-table binary search: key table in stbs_ram, search sequencer, config register.
// Depends on stbs_pkg and stbs_ram.
//
//  channel  | signals                   | handshake
//  ---------+---------------------------+--------------------------------------
//  command  | start, busy, i_cmd        | beat taken when start high, busy low
//  result   | o_res_valid, o_res        | one-cycle strobe, cannot be held off
//  config   | i_cfg_we, i_cfg_wdata     | entry_count written when i_cfg_we high
//
// A write beat gives no result; busy stays low. A search issues one table read
// per cycle, the compare feeding the next read address; the result strobes in
// the cycle after the last probe.
// Synchronous active-low reset clears control and entry_count; the table is
// undefined until written. The receiver cannot stall the result.
module sorted_table_binary_search_top
    import stbs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned KEY_BITS    = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_res_valid,
    output t_res                  o_res,
    input  logic                  i_cfg_we,
    input  logic [COUNT_BITS-1:0] i_cfg_wdata
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned MW = (AW > COUNT_BITS) ? AW : COUNT_BITS;
    localparam int unsigned IW = (AW > INDEX_BITS) ? AW : INDEX_BITS;

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } t_state;

    t_state                     r_state, n_state;
    logic [COUNT_BITS-1:0]      r_entry_count;
    logic [COUNT_BITS-1:0]      r_lo, n_lo;
    logic [COUNT_BITS-1:0]      r_hx, n_hx;
    logic [COUNT_BITS-1:0]      r_mid, n_mid;
    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic                       r_res_valid, n_res_valid;
    t_res                       r_res, n_res;

    logic                       accept;
    logic [COUNT_BITS-1:0]      count_eff;
    logic signed [63:0]         key_wide;
    logic signed [KEY_BITS-1:0] key_in;
    logic [IW-1:0]              idx_ext;
    logic                       wr_en;
    logic                       rd_en;
    logic [COUNT_BITS-1:0]      rd_mid;
    logic [MW-1:0]              rd_mid_ext;
    logic [KEY_BITS-1:0]        rdata;
    logic signed [KEY_BITS-1:0] probe_key;
    logic [COUNT_BITS:0]        mid_sum;

    assign accept    = start && !busy;
    assign count_eff = (32'(r_entry_count) > TABLE_DEPTH) ? COUNT_BITS'(TABLE_DEPTH)
                                                          : r_entry_count;
    assign key_wide  = 64'(i_cmd.key_value);
    assign key_in    = key_wide[KEY_BITS-1:0];
    assign idx_ext   = IW'(i_cmd.entry_index);
    assign wr_en     = accept && (i_cmd.func == FUNC_WRITE)
                       && (32'(i_cmd.entry_index) < TABLE_DEPTH);
    assign probe_key = rdata;
    assign mid_sum   = {1'b0, n_lo} + {1'b0, n_hx} - (COUNT_BITS+1)'(1);
    assign rd_mid    = mid_sum[COUNT_BITS:1];
    assign rd_mid_ext = MW'(rd_mid);

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hx        = r_hx;
        n_key       = r_key;
        n_res_valid = 1'b0;
        n_res       = r_res;
        rd_en       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd.func == FUNC_SEARCH)) begin
                    n_lo  = '0;
                    n_hx  = count_eff;
                    n_key = key_in;
                end
            end
            S_PROBE: begin
                priority if (probe_key == r_key) begin
                    n_lo = r_hx;
                end else if (probe_key > r_key) begin
                    n_hx = (r_mid == '0) ? r_lo : r_mid;
                end else begin
                    n_lo = r_mid + COUNT_BITS'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if ((r_state == S_IDLE && accept && i_cmd.func == FUNC_SEARCH)
            || r_state == S_PROBE) begin
            if (r_state == S_PROBE && probe_key == r_key) begin
                n_state     = S_IDLE;
                n_res_valid = 1'b1;
                n_res.position = r_mid + COUNT_BITS'(1);
                n_res.found    = 1'b1;
            end else if (n_lo < n_hx) begin
                n_state = S_PROBE;
                rd_en   = 1'b1;
            end else begin
                n_state     = S_IDLE;
                n_res_valid = 1'b1;
                n_res.position = '0;
                n_res.found    = 1'b0;
            end
        end
        n_mid = rd_en ? rd_mid : r_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_res_valid   <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
        r_lo  <= n_lo;
        r_hx  <= n_hx;
        r_mid <= n_mid;
        r_key <= n_key;
        r_res <= n_res;
    end

    stbs_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (key_in),
        .i_re    (rd_en),
        .i_raddr (rd_mid_ext[AW-1:0]),
        .o_rdata (rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(r_state == S_PROBE)
                        || $past(start && !busy && i_cmd.func == FUNC_SEARCH)))
        else $error("result beat without a search in flight");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.found == (o_res.position != '0)))
        else $error("found flag disagrees with position");

    a_mid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> ((r_mid >= r_lo) && (r_mid < r_hx)))
        else $error("probe index outside live range");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !wr_en)
        else $error("table written during a search");

endmodule
